@@ rtl/mrs_pkg.sv @@
package mrs_pkg;

    // Store sizes
    localparam int COIL_COUNT  = 10;
    localparam int HOLD_COUNT  = 16;
    localparam int INPUT_COUNT = 16;
    localparam int BUF_BYTES   = 256;

    localparam int BUF_AW   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int COIL_IW  = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
    localparam int HOLD_IW  = (HOLD_COUNT > 1) ? $clog2(HOLD_COUNT) : 1;
    localparam int INPUT_IW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int MAX_N    = (COIL_COUNT > HOLD_COUNT)
                              ? ((COIL_COUNT > INPUT_COUNT) ? COIL_COUNT : INPUT_COUNT)
                              : ((HOLD_COUNT > INPUT_COUNT) ? HOLD_COUNT : INPUT_COUNT);
    localparam int IDX_W    = $clog2(MAX_N + 1);

    // Commands
    localparam logic [1:0] CMD_RX   = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_INWR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_STATION = 3'd0;
    localparam logic [2:0] CFG_GAP     = 3'd1;
    localparam logic [2:0] CFG_COIL    = 3'd2;
    localparam logic [2:0] CFG_HOLD    = 3'd3;
    localparam logic [2:0] CFG_INPUT   = 3'd4;

    // Function codes
    localparam logic [7:0] FC_RD_COILS  = 8'd1;
    localparam logic [7:0] FC_RD_DISC   = 8'd2;
    localparam logic [7:0] FC_RD_HOLD   = 8'd3;
    localparam logic [7:0] FC_RD_INPUT  = 8'd4;
    localparam logic [7:0] FC_WR_COIL   = 8'd5;
    localparam logic [7:0] FC_WR_REG    = 8'd6;
    localparam logic [7:0] FC_WR_COILS  = 8'd15;
    localparam logic [7:0] FC_WR_REGS   = 8'd16;

    // Exception codes
    localparam logic [7:0] EXC_NONE  = 8'd0;
    localparam logic [7:0] EXC_FUNC  = 8'd1;
    localparam logic [7:0] EXC_ADDR  = 8'd2;
    localparam logic [7:0] EXC_VALUE = 8'd3;

    localparam logic [15:0] COIL_ON      = 16'hFF00;
    localparam logic [7:0]  EXC_FLAG     = 8'h80;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] MAX_COILS_RD = 16'd960;
    localparam logic [15:0] MAX_REGS_RD  = 16'd125;
    localparam logic [8:0]  MAX_LEN      = 9'd250;
    localparam logic [8:0]  MIN_LEN      = 9'd8;
    localparam logic [8:0]  CNT_MAX      = 9'd511;

    typedef struct packed {
        logic [7:0]  station;
        logic [7:0]  gap;
        logic [15:0] coil_base;
        logic [15:0] hold_base;
        logic [15:0] input_base;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [8:0]  len;
        logic [15:0] tick;
    } t_job;

    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [15:0] value;
    } t_inwr;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_txb;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/mrs_ram.sv @@
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/mrs_txq.sv @@
module mrs_txq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrs_pkg::t_txb i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mrs_pkg::t_txb o_head
);
    import mrs_pkg::*;

    t_txb       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_head  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end
endmodule

@@ rtl/mrs_front.sv @@
module mrs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_command,
    input  logic [7:0]                i_rx_byte,
    input  logic [3:0]                i_input_index,
    input  logic [15:0]               i_input_value,
    input  mrs_pkg::t_cfg             i_cfg,
    input  logic                      i_take,
    output mrs_pkg::t_job             o_job,
    output mrs_pkg::t_inwr            o_inwr,
    output logic                      o_ram_we,
    output logic [mrs_pkg::BUF_AW-1:0] o_ram_waddr,
    output logic [7:0]                o_ram_wdata
);
    import mrs_pkg::*;

    logic [8:0]  r_count;
    logic        r_collect;
    logic [7:0]  r_sil;
    logic [15:0] r_tick;
    logic [7:0]  r_first;
    t_job        r_job;
    logic        w_rx, w_tick;
    logic [7:0]  w_sil;

    assign w_rx   = i_accept && (i_command == CMD_RX);
    assign w_tick = i_accept && (i_command == CMD_TICK);
    assign w_sil  = (r_sil == 8'hFF) ? r_sil : r_sil + 8'd1;

    assign o_job       = r_job;
    assign o_inwr      = '{en: i_accept && (i_command == CMD_INWR),
                           idx: i_input_index, value: i_input_value};
    assign o_ram_we    = w_rx && r_collect && ({23'd0, r_count} < BUF_BYTES);
    assign o_ram_waddr = r_count[BUF_AW-1:0];
    assign o_ram_wdata = i_rx_byte;

    // Hold the first byte of the frame
    always_ff @(posedge i_clk) begin
        if (w_rx && r_collect && r_count == 9'd0) begin
            r_first <= i_rx_byte;
        end
    end

    // Collect bytes and end frames on silence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 9'd0;
            r_collect <= 1'b0;
            r_sil     <= 8'd0;
            r_tick    <= 16'd0;
            r_job     <= '0;
        end else begin
            if (i_take) begin
                r_job.valid <= 1'b0;
            end
            if (w_rx) begin
                if (r_collect) begin
                    if (r_count == 9'd0 && i_rx_byte != i_cfg.station) begin
                        r_collect <= 1'b0;
                    end
                    if (r_count != CNT_MAX) begin
                        r_count <= r_count + 9'd1;
                    end
                end
                r_sil <= 8'd0;
            end else if (w_tick) begin
                r_tick <= r_tick + 16'd1;
                if (w_sil > i_cfg.gap) begin
                    r_count   <= 9'd0;
                    r_collect <= 1'b1;
                    r_sil     <= 8'd0;
                    if (r_count >= MIN_LEN && r_first == i_cfg.station) begin
                        r_job <= '{valid: 1'b1, len: r_count, tick: r_tick + 16'd1};
                    end
                end else begin
                    r_sil <= w_sil;
                end
            end
        end
    end
endmodule

@@ rtl/mrs_back.sv @@
module mrs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mrs_pkg::t_cfg              i_cfg,
    input  mrs_pkg::t_job              i_job,
    output logic                       o_take,
    output logic                       o_busy,
    input  mrs_pkg::t_inwr             i_inwr,
    output logic [mrs_pkg::BUF_AW-1:0] o_ram_raddr,
    input  logic [7:0]                 i_ram_rdata,
    output logic                       o_tx_push,
    output mrs_pkg::t_txb              o_tx_data,
    input  logic                       i_tx_full
);
    import mrs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]            r_state;
    logic [8:0]            r_len, r_idx, r_end, r_pidx;
    logic [15:0]           r_tick, r_tprev, r_crc;
    logic                  r_pv;
    logic [7:0]            r_hdr [6];
    logic [7:0]            r_b0, r_b1, r_code, r_b2, r_hi;
    logic [IDX_W-1:0]      r_base;
    logic [6:0]            r_rlen, r_wn, r_wi, r_wp, r_k;
    logic [COIL_COUNT-1:0] r_coil;
    logic [15:0]           r_hold [HOLD_COUNT];
    logic [15:0]           r_inw [INPUT_COUNT];

    logic [7:0]  w_fc, w_byte, w_wbyte, w_rb, w_cbyte;
    logic [15:0] w_adr, w_cnt, w_word;
    logic [16:0] w_end, w_clim, w_hlim, w_ilim;
    logic        w_c_bad, w_h_bad, w_i_bad, w_c_one, w_h_one, w_fc_ok;
    logic [7:0]  w_code, w_nb;
    logic [IDX_W-1:0] w_base;
    logic [6:0]  w_rlen, w_m;
    logic [IDX_W:0] w_widx;
    logic [9:0]  w_bi [8];
    logic [10:0] w_ci [8];
    logic [IDX_W:0] w_rel [COIL_COUNT];
    logic [COIL_COUNT-1:0] w_cwe;
    logic        w_exc, w_push;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_take      = (r_state == ST_IDLE) && i_job.valid;
    assign o_ram_raddr = (r_state == ST_SCAN) ? r_idx[BUF_AW-1:0]
                                              : BUF_AW'(r_wi + 7'd7);

    // Decode and check the request header, and size the response
    always_comb begin
        w_fc    = r_hdr[1];
        w_adr   = {r_hdr[2], r_hdr[3]};
        w_cnt   = {r_hdr[4], r_hdr[5]};
        w_end   = {1'b0, w_adr} + {1'b0, w_cnt};
        w_clim  = {1'b0, i_cfg.coil_base} + 17'(COIL_COUNT);
        w_hlim  = {1'b0, i_cfg.hold_base} + 17'(HOLD_COUNT);
        w_ilim  = {1'b0, i_cfg.input_base} + 17'(INPUT_COUNT);
        w_c_bad = (w_adr < i_cfg.coil_base) || (w_end > w_clim);
        w_h_bad = (w_adr < i_cfg.hold_base) || (w_end > w_hlim);
        w_i_bad = (w_adr < i_cfg.input_base) || (w_end > w_ilim);
        w_c_one = (w_adr < i_cfg.coil_base) || ({1'b0, w_adr} >= w_clim);
        w_h_one = (w_adr < i_cfg.hold_base) || ({1'b0, w_adr} >= w_hlim);
        w_fc_ok = (w_fc == FC_RD_COILS) || (w_fc == FC_RD_DISC) || (w_fc == FC_RD_HOLD)
               || (w_fc == FC_RD_INPUT) || (w_fc == FC_WR_COIL) || (w_fc == FC_WR_REG)
               || (w_fc == FC_WR_COILS) || (w_fc == FC_WR_REGS);
        w_nb    = 8'(({1'b0, w_cnt[6:0]} + 8'd7) >> 3);
        w_code  = EXC_NONE;
        priority if (!w_fc_ok) begin
            w_code = EXC_FUNC;
        end else if (r_len > MAX_LEN) begin
            w_code = EXC_VALUE;
        end else if (r_crc != {r_b0, r_b1}) begin
            w_code = EXC_VALUE;
        end else begin
            unique case (w_fc)
                FC_RD_COILS, FC_RD_DISC: begin
                    priority if (w_cnt > MAX_COILS_RD) w_code = EXC_VALUE;
                    else if (w_c_bad) w_code = EXC_ADDR;
                    else w_code = EXC_NONE;
                end
                FC_WR_COIL: begin
                    priority if (w_c_one) w_code = EXC_ADDR;
                    else if (w_cnt != COIL_ON && w_cnt != 16'd0) w_code = EXC_VALUE;
                    else w_code = EXC_NONE;
                end
                FC_WR_COILS: w_code = w_c_bad ? EXC_ADDR : EXC_NONE;
                FC_RD_HOLD: begin
                    priority if (w_cnt > MAX_REGS_RD) w_code = EXC_VALUE;
                    else if (w_h_bad) w_code = EXC_ADDR;
                    else w_code = EXC_NONE;
                end
                FC_RD_INPUT: begin
                    priority if (w_cnt > MAX_REGS_RD) w_code = EXC_VALUE;
                    else if (w_i_bad) w_code = EXC_ADDR;
                    else w_code = EXC_NONE;
                end
                FC_WR_REG:  w_code = w_h_one ? EXC_ADDR : EXC_NONE;
                FC_WR_REGS: w_code = w_h_bad ? EXC_ADDR : EXC_NONE;
                default:    w_code = EXC_FUNC;
            endcase
        end
        unique case (w_fc)
            FC_RD_COILS, FC_RD_DISC, FC_WR_COIL, FC_WR_COILS:
                w_base = IDX_W'(w_adr - i_cfg.coil_base);
            FC_RD_INPUT: w_base = IDX_W'(w_adr - i_cfg.input_base);
            default:     w_base = IDX_W'(w_adr - i_cfg.hold_base);
        endcase
        priority if (w_code != EXC_NONE) begin
            w_rlen = 7'd3;
        end else if (w_fc == FC_RD_COILS || w_fc == FC_RD_DISC) begin
            w_rlen = 7'd3 + w_nb[6:0];
        end else if (w_fc == FC_RD_HOLD || w_fc == FC_RD_INPUT) begin
            w_rlen = 7'd3 + {w_cnt[5:0], 1'b0};
        end else begin
            w_rlen = 7'd6;
        end
    end

    // Scan byte zero beyond the frame store, write-phase byte zero beyond the frame
    assign w_byte  = ({23'd0, r_pidx} < BUF_BYTES) ? i_ram_rdata : 8'd0;
    assign w_wbyte = (({2'd0, r_wp} + 9'd7) < r_len) ? i_ram_rdata : 8'd0;

    // Coil write enables for a multiple-coil write beat
    always_comb begin
        for (int c = 0; c < COIL_COUNT; c++) begin
            w_rel[c] = (IDX_W + 1)'(c) - {1'b0, r_base};
            w_cwe[c] = ((IDX_W + 1)'(c) >= {1'b0, r_base})
                    && ({{(16 - IDX_W - 1){1'b0}}, w_rel[c]} < w_cnt)
                    && ({{(11 - IDX_W){1'b0}}, w_rel[c][IDX_W:3]} == {2'd0, r_wp});
        end
    end

    // Build the response byte
    always_comb begin
        w_exc = (r_code != EXC_NONE);
        w_m   = r_k - 7'd3;
        for (int b = 0; b < 8; b++) begin
            w_bi[b] = {w_m, 3'b000} + 10'(b);
            w_ci[b] = {1'b0, w_bi[b]} + 11'(r_base);
            w_cbyte[b] = ({6'd0, w_bi[b]} < w_cnt) && ({21'd0, w_ci[b]} < COIL_COUNT)
                         ? r_coil[w_ci[b][COIL_IW-1:0]] : 1'b0;
        end
        w_widx = {1'b0, r_base} + (IDX_W + 1)'(w_m[6:1]);
        if (w_fc == FC_RD_INPUT) begin
            w_word = ({{(31 - IDX_W){1'b0}}, w_widx} < INPUT_COUNT)
                     ? r_inw[w_widx[INPUT_IW-1:0]] : 16'd0;
        end else begin
            w_word = ({{(31 - IDX_W){1'b0}}, w_widx} < HOLD_COUNT)
                     ? r_hold[w_widx[HOLD_IW-1:0]] : 16'd0;
        end
        priority if (r_k == r_rlen) begin
            w_rb = r_crc[7:0];
        end else if (r_k == r_rlen + 7'd1) begin
            w_rb = r_crc[15:8];
        end else if (r_k == 7'd0) begin
            w_rb = r_hdr[0];
        end else if (r_k == 7'd1) begin
            w_rb = w_exc ? (r_hdr[1] | EXC_FLAG) : r_hdr[1];
        end else if (r_k == 7'd2) begin
            w_rb = w_exc ? r_code : r_b2;
        end else if (w_fc == FC_RD_COILS || w_fc == FC_RD_DISC) begin
            w_rb = w_cbyte;
        end else if (w_fc == FC_RD_HOLD || w_fc == FC_RD_INPUT) begin
            w_rb = w_m[0] ? w_word[7:0] : w_word[15:8];
        end else begin
            w_rb = (r_k < 7'd6) ? r_hdr[3'(r_k)] : 8'd0;
        end
    end

    assign w_push    = (r_state == ST_EMIT) && !i_tx_full;
    assign o_tx_push = w_push;
    assign o_tx_data = '{data: w_rb, last: (r_k == r_rlen + 7'd1)};

    // Sequence one request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pv    <= 1'b0;
            r_tprev <= 16'd0;
            r_coil  <= '0;
            for (int i = 0; i < HOLD_COUNT; i++) r_hold[i] <= 16'd0;
            for (int i = 0; i < INPUT_COUNT; i++) r_inw[i] <= 16'd0;
        end else begin
            if (i_inwr.en && ({28'd0, i_inwr.idx} < INPUT_COUNT)) begin
                r_inw[i_inwr.idx[INPUT_IW-1:0]] <= i_inwr.value;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job.valid) begin
                        r_len   <= i_job.len;
                        r_tick  <= i_job.tick;
                        r_idx   <= 9'd0;
                        r_end   <= (i_job.len > MAX_LEN) ? MIN_LEN : i_job.len;
                        r_crc   <= CRC_INIT;
                        r_pv    <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // issue reads, process the beat from last cycle
                    r_pv <= (r_idx < r_end);
                    if (r_idx < r_end) begin
                        r_pidx <= r_idx;
                        r_idx  <= r_idx + 9'd1;
                    end
                    if (r_pv) begin
                        if (r_pidx < 9'd6) r_hdr[3'(r_pidx)] <= w_byte;
                        if (r_pidx + 9'd2 < r_len) r_crc <= crc_byte(r_crc, w_byte);
                        r_b0 <= w_byte;
                        r_b1 <= r_b0;
                    end
                    if (!r_pv && r_idx >= r_end) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_code <= w_code;
                    r_base <= w_base;
                    r_rlen <= w_rlen;
                    r_b2   <= (w_fc == FC_RD_COILS || w_fc == FC_RD_DISC) ? w_nb
                            : (w_fc == FC_RD_HOLD || w_fc == FC_RD_INPUT)
                              ? {w_cnt[6:0], 1'b0} : r_hdr[2];
                    r_wn   <= (w_fc == FC_WR_COILS) ? w_nb[6:0] : {w_cnt[5:0], 1'b0};
                    r_wi   <= 7'd0;
                    r_pv   <= 1'b0;
                    r_k    <= 7'd0;
                    r_crc  <= CRC_INIT;
                    if (w_code == EXC_NONE && w_fc == FC_WR_COIL) begin
                        r_coil[w_base[COIL_IW-1:0]] <= (w_cnt == COIL_ON);
                    end
                    if (w_code == EXC_NONE && w_fc == FC_WR_REG) begin
                        r_hold[w_base[HOLD_IW-1:0]] <= w_cnt;
                    end
                    if (w_code == EXC_NONE && w_cnt != 16'd0
                        && (w_fc == FC_WR_COILS || w_fc == FC_WR_REGS)) begin
                        r_state <= ST_WRITE;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_WRITE: begin
                    r_pv <= (r_wi < r_wn);
                    if (r_wi < r_wn) begin
                        r_wp <= r_wi;
                        r_wi <= r_wi + 7'd1;
                    end
                    if (r_pv) begin
                        if (w_fc == FC_WR_COILS) begin
                            for (int c = 0; c < COIL_COUNT; c++) begin
                                if (w_cwe[c]) r_coil[c] <= w_wbyte[w_rel[c][2:0]];
                            end
                        end else if (!r_wp[0]) begin
                            r_hi <= w_wbyte;
                        end else begin
                            r_hold[HOLD_IW'(r_base + IDX_W'(r_wp[6:1]))] <= {r_hi, w_wbyte};
                        end
                    end
                    if (!r_pv && r_wi >= r_wn) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_push) begin
                        if (r_k < r_rlen) r_crc <= crc_byte(r_crc, w_rb);
                        r_k <= r_k + 7'd1;
                        if (r_k == r_rlen + 7'd1) r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_hold[HOLD_COUNT - 1] <= r_tick - r_tprev;
                    r_tprev <= r_tick;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/modbus_rtu_slave_core.sv @@
// Modbus RTU slave core.
// The input accepts a received byte, an input register write or a tick whenever it is not full.
// A frame-ending tick hands a valid frame on: it is read back from the frame store (only
// its first 8 bytes above 250 bytes), a multiple write writes its payload, and the response
// goes out at 1 byte a cycle while the queue has room. Input then stays full through ST_DONE.
// Reset (synchronous, active low) clears coils, registers, config, queue; frame store is kept.
module modbus_rtu_slave_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [3:0]  i_input_index,
    input  logic [15:0] i_input_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mrs_pkg::*;

    t_cfg              r_cfg;
    t_job              w_job;
    t_inwr             w_inwr;
    t_txb              w_txd, w_head;
    logic              w_take, w_busy, w_we, w_tpush, w_tfull;
    logic [BUF_AW-1:0] w_waddr, w_raddr;
    logic [7:0]        w_wdata, w_rdata;

    assign o_cfg_ready = 1'b1;
    assign full        = w_job.valid || w_busy;
    assign o_tx_byte   = w_head.data;
    assign o_last_byte = w_head.last;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{station: 8'd1, gap: 8'd5, coil_base: 16'd0,
                       hold_base: 16'd0, input_base: 16'd0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STATION: r_cfg.station    <= i_cfg_data[7:0];
                CFG_GAP:     r_cfg.gap        <= i_cfg_data[7:0];
                CFG_COIL:    r_cfg.coil_base  <= i_cfg_data;
                CFG_HOLD:    r_cfg.hold_base  <= i_cfg_data;
                CFG_INPUT:   r_cfg.input_base <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    mrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !full),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_input_index(i_input_index),
        .i_input_value(i_input_value),
        .i_cfg        (r_cfg),
        .i_take       (w_take),
        .o_job        (w_job),
        .o_inwr       (w_inwr),
        .o_ram_we     (w_we),
        .o_ram_waddr  (w_waddr),
        .o_ram_wdata  (w_wdata)
    );

    mrs_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    mrs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (w_job),
        .o_take     (w_take),
        .o_busy     (w_busy),
        .i_inwr     (w_inwr),
        .o_ram_raddr(w_raddr),
        .i_ram_rdata(w_rdata),
        .o_tx_push  (w_tpush),
        .o_tx_data  (w_txd),
        .i_tx_full  (w_tfull)
    );

    mrs_txq u_txq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_tpush),
        .i_data (w_txd),
        .o_full (w_tfull),
        .i_pop  (pop),
        .o_empty(empty),
        .o_head (w_head)
    );

`ifndef SYNTH
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> full) else $error("input open while request in progress");
    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_busy) else $error("frame store written during request");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> w_busy) else $error("taken request not started");
`endif
endmodule
